### hw/rtl/obb_pkg.sv
// Package for the box pair overlap test: widths, lane types and helpers.
// Used by every module of the block; depends on nothing.
`default_nettype none

package obb_pkg;

  localparam int unsigned CoordWidth = 16;
  localparam int unsigned RotWidth   = 16;
  localparam int unsigned FieldWidth = 48;
  // t = sum of three R*c products plus a shifted difference, Q.14.
  localparam int unsigned TWidth     = CoordWidth + RotWidth + 3;
  // Sums of products of t with rotation entries, Q.28.
  localparam int unsigned WideWidth  = TWidth + RotWidth + 4;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [RotWidth-1:0]   rot_t;
  // Absolute rotation entry plus one LSB; fits in RotWidth bits unsigned plus one.
  typedef logic signed [RotWidth+1:0]   arot_t;
  typedef logic signed [TWidth-1:0]     tval_t;
  typedef logic signed [WideWidth-1:0]  wide_t;

  typedef coord_t [2:0]      vec_t;
  typedef rot_t   [2:0][2:0] mat_t;
  typedef arot_t  [2:0][2:0] amat_t;
  typedef tval_t  [2:0]      tvec_t;

  // Unpacks component k of a packed field; a component beyond the field reads as zero.
  function automatic coord_t get_coord(input logic [FieldWidth-1:0] f, input int unsigned k);
    logic [CoordWidth-1:0] r;
    for (int unsigned b = 0; b < CoordWidth; b++) begin
      r[b] = ((k * CoordWidth + b) < FieldWidth) ? f[k * CoordWidth + b] : 1'b0;
    end
    return coord_t'(r);
  endfunction

  function automatic rot_t get_rot(input logic [FieldWidth-1:0] f, input int unsigned k);
    return rot_t'(f[k*RotWidth +: RotWidth]);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/obb_front.sv
// Stage 1 and 2: unpack, absolute rotation, translation vector t.
// Depends on obb_pkg.
`default_nettype none

module obb_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [47:0]          a_center_i,
  input  wire logic [47:0]          a_half_i,
  input  wire logic [47:0]          b_center_i,
  input  wire logic [47:0]          b_half_i,
  input  wire logic [47:0]          rot_row0_i,
  input  wire logic [47:0]          rot_row1_i,
  input  wire logic [47:0]          rot_row2_i,
  input  wire logic [47:0]          shift_i,
  output logic                      valid_o,
  output obb_pkg::vec_t             ah_o,
  output obb_pkg::vec_t             bh_o,
  output obb_pkg::mat_t             r_o,
  output obb_pkg::amat_t            ar_o,
  output obb_pkg::tvec_t            t_o
);

  obb_pkg::vec_t  ac, ah, bc, bh, sh;
  obb_pkg::mat_t  r;
  obb_pkg::vec_t  ah_q, bh_q, ah2_q, bh2_q;
  obb_pkg::mat_t  r_q, r2_q;
  obb_pkg::amat_t ar_q, ar2_q;
  obb_pkg::vec_t  bc_q;
  obb_pkg::tvec_t d_q, t_q;
  logic           v1_q, v2_q;

  // Unpack the packed fields.
  always_comb begin
    for (int unsigned i = 0; i < 3; i++) begin
      ac[i] = obb_pkg::get_coord(a_center_i, i);
      ah[i] = obb_pkg::get_coord(a_half_i, i);
      bc[i] = obb_pkg::get_coord(b_center_i, i);
      bh[i] = obb_pkg::get_coord(b_half_i, i);
      sh[i] = obb_pkg::get_coord(shift_i, i);
      r[0][i] = obb_pkg::get_rot(rot_row0_i, i);
      r[1][i] = obb_pkg::get_rot(rot_row1_i, i);
      r[2][i] = obb_pkg::get_rot(rot_row2_i, i);
    end
  end

  // Stage 1: padded absolute rotation and the shift minus center term.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ah_q <= ah;
      bh_q <= bh;
      bc_q <= bc;
      r_q  <= r;
      for (int unsigned i = 0; i < 3; i++) begin
        d_q[i] <= (obb_pkg::tval_t'(sh[i]) - obb_pkg::tval_t'(ac[i])) <<< 14;
        for (int unsigned j = 0; j < 3; j++) begin
          ar_q[i][j] <= (r[i][j] < 0) ?
                        -obb_pkg::arot_t'(r[i][j]) + obb_pkg::arot_t'(1) :
                        obb_pkg::arot_t'(r[i][j]) + obb_pkg::arot_t'(1);
        end
      end
    end
  end

  // Stage 2: t = R * b_center + d.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ah2_q <= ah_q;
      bh2_q <= bh_q;
      r2_q  <= r_q;
      ar2_q <= ar_q;
      for (int unsigned i = 0; i < 3; i++) begin
        t_q[i] <= obb_pkg::tval_t'(r_q[i][0]) * obb_pkg::tval_t'(bc_q[0]) +
                  obb_pkg::tval_t'(r_q[i][1]) * obb_pkg::tval_t'(bc_q[1]) +
                  obb_pkg::tval_t'(r_q[i][2]) * obb_pkg::tval_t'(bc_q[2]) + d_q[i];
      end
    end
  end

  assign valid_o = v2_q;
  assign ah_o    = ah2_q;
  assign bh_o    = bh2_q;
  assign r_o     = r2_q;
  assign ar_o    = ar2_q;
  assign t_o     = t_q;

endmodule

`default_nettype wire

### hw/rtl/obb_axes.sv
// Stages 3 and 4: projections and radii for the 15 axes, then the compare.
// Depends on obb_pkg.
`default_nettype none

module obb_axes (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  obb_pkg::vec_t       ah_i,
  input  obb_pkg::vec_t       bh_i,
  input  obb_pkg::mat_t       r_i,
  input  obb_pkg::amat_t      ar_i,
  input  obb_pkg::tvec_t      t_i,
  output logic                valid_o,
  output logic                overlap_o
);

  typedef obb_pkg::wide_t [14:0] wvec_t;

  wvec_t      proj_q, rad_q;
  logic       v3_q, v4_q, ov_q;
  logic [14:0] sep;

  // Stage 3: per-axis projection of t and projected radius.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= valid_i;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int unsigned i = 0; i < 3; i++) begin
        // Axes of box a, scaled to Q.28.
        proj_q[i] <= obb_pkg::wide_t'(t_i[i]) <<< 14;
        rad_q[i]  <= (obb_pkg::wide_t'(ah_i[i]) <<< 28) +
                     ((obb_pkg::wide_t'(bh_i[0]) * obb_pkg::wide_t'(ar_i[i][0]) +
                       obb_pkg::wide_t'(bh_i[1]) * obb_pkg::wide_t'(ar_i[i][1]) +
                       obb_pkg::wide_t'(bh_i[2]) * obb_pkg::wide_t'(ar_i[i][2])) <<< 14);
        // Axes of box b.
        proj_q[3+i] <= obb_pkg::wide_t'(t_i[0]) * obb_pkg::wide_t'(r_i[0][i]) +
                       obb_pkg::wide_t'(t_i[1]) * obb_pkg::wide_t'(r_i[1][i]) +
                       obb_pkg::wide_t'(t_i[2]) * obb_pkg::wide_t'(r_i[2][i]);
        rad_q[3+i]  <= (obb_pkg::wide_t'(bh_i[i]) <<< 28) +
                       ((obb_pkg::wide_t'(ah_i[0]) * obb_pkg::wide_t'(ar_i[0][i]) +
                         obb_pkg::wide_t'(ah_i[1]) * obb_pkg::wide_t'(ar_i[1][i]) +
                         obb_pkg::wide_t'(ah_i[2]) * obb_pkg::wide_t'(ar_i[2][i])) <<< 14);
        // Cross axes.
        for (int unsigned j = 0; j < 3; j++) begin
          proj_q[6+3*i+j] <=
            obb_pkg::wide_t'(t_i[(i+2)%3]) * obb_pkg::wide_t'(r_i[(i+1)%3][j]) -
            obb_pkg::wide_t'(t_i[(i+1)%3]) * obb_pkg::wide_t'(r_i[(i+2)%3][j]);
          rad_q[6+3*i+j]  <=
            (obb_pkg::wide_t'(ah_i[(i+1)%3]) * obb_pkg::wide_t'(ar_i[(i+2)%3][j]) +
             obb_pkg::wide_t'(ah_i[(i+2)%3]) * obb_pkg::wide_t'(ar_i[(i+1)%3][j]) +
             obb_pkg::wide_t'(bh_i[(j+1)%3]) * obb_pkg::wide_t'(ar_i[i][(j+2)%3]) +
             obb_pkg::wide_t'(bh_i[(j+2)%3]) * obb_pkg::wide_t'(ar_i[i][(j+1)%3]))
            <<< 14;
        end
      end
    end
  end

  // Strict test on each axis: separated when |proj| > radius.
  always_comb begin
    for (int unsigned k = 0; k < 15; k++) begin
      sep[k] = (proj_q[k] > rad_q[k]) || (-proj_q[k] > rad_q[k]);
    end
  end

  // Stage 4: combine the 15 axis results.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ov_q <= ~(|sep);
    end
  end

  assign valid_o   = v4_q;
  assign overlap_o = ov_q;

endmodule

`default_nettype wire

### hw/rtl/obb_pair_overlap_test.sv
// A result passes through the four pipeline stages and then the output register.
// Throughput: one transaction per cycle; the pipeline advances while the skid register is empty.
// Input ready comes from a register, so the output side never reaches it combinationally.
// Reset clears all valid bits; payload registers are not reset.
`default_nettype none

module obb_pair_overlap_test (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire logic [47:0] a_center_i,
  input  wire logic [47:0] a_half_i,
  input  wire logic [47:0] b_center_i,
  input  wire logic [47:0] b_half_i,
  input  wire logic [47:0] rot_row0_i,
  input  wire logic [47:0] rot_row1_i,
  input  wire logic [47:0] rot_row2_i,
  input  wire logic [47:0] shift_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output logic             overlap_o
);

  obb_pkg::vec_t  ah, bh;
  obb_pkg::mat_t  r;
  obb_pkg::amat_t ar;
  obb_pkg::tvec_t t;
  logic           fv, pv, pov;
  logic           en, out_free;
  logic           out_v_q, out_d_q;
  logic           sk_v_q, sk_d_q;

  // The whole pipeline advances while the skid register is empty.
  assign en       = !sk_v_q;
  assign ready_o  = en;
  assign out_free = !out_v_q || ready_i;

  obb_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(valid_i),
    .a_center_i, .a_half_i, .b_center_i, .b_half_i,
    .rot_row0_i, .rot_row1_i, .rot_row2_i, .shift_i,
    .valid_o(fv), .ah_o(ah), .bh_o(bh), .r_o(r), .ar_o(ar), .t_o(t)
  );

  obb_axes u_axes (
    .clk_i, .rst_ni, .en_i(en), .valid_i(fv),
    .ah_i(ah), .bh_i(bh), .r_i(r), .ar_i(ar), .t_i(t),
    .valid_o(pv), .overlap_o(pov)
  );

  // Output register with a one-entry skid register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (out_free) begin
      if (sk_v_q) begin
        out_v_q <= 1'b1;
        sk_v_q  <= 1'b0;
      end else begin
        out_v_q <= pv;
      end
    end else if (en && pv) begin
      sk_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_d_q <= sk_v_q ? sk_d_q : pov;
    end else if (en) begin
      sk_d_q <= pov;
    end
  end

  assign valid_o   = out_v_q;
  assign overlap_o = out_d_q;

`ifndef SYNTH
  // A filled skid register sits behind a held result and stalls intake.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_v_q |-> (out_v_q && !ready_o)) else $error("skid entry without a held result");
  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> (valid_o && $stable(overlap_o))) else $error("result lost");
  // Pipeline valid feeds the output when advancing.
  a_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && pv) |=> out_v_q) else $error("result dropped");
`endif

endmodule

`default_nettype wire
